/* hw/rtl/scancode_to_ascii_with_fifo_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the scan code decoder
// The macros use the clock clk and the active-low reset rst_n of the module
// that uses them. Synthesis builds get empty macros.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_WITH_FIFO_TOP_DEFINES_SVH
`define SCANCODE_TO_ASCII_WITH_FIFO_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define SC2A_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sc2a assertion failed");

// An implication that must hold at every clock edge outside reset.
`define SC2A_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sc2a assertion failed");

// An implication whose consequence is checked at the next clock edge.
`define SC2A_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sc2a assertion failed");

`else

`define SC2A_ASSERT(lbl, prop)
`define SC2A_ASSERT_IMP(lbl, ante, cons)
`define SC2A_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* hw/rtl/sc2a_pkg.sv */
// ----------------------------------------------------------------------------
// sc2a_pkg
// Types, constants and key tables shared by the scan code decoder modules.
// ----------------------------------------------------------------------------
package sc2a_pkg;

    // Ring geometry: the ring holds at most RING_DEPTH-1 characters.
    localparam int RING_DEPTH = 256;
    localparam int PTR_W      = $clog2(RING_DEPTH);

    // Character and scan code widths.
    localparam int CHAR_W = 7;
    localparam int CODE_W = 8;

    // Key tables cover make codes 0..63; codes 59..63 decode to nothing.
    localparam int TAB_DEPTH = 64;
    localparam int TAB_IDX_W = $clog2(TAB_DEPTH);

    // Item kinds on the input channel.
    typedef enum logic {
        OP_SCAN = 1'b0,
        OP_READ = 1'b1
    } opcode_t;

    // Scan codes with a special meaning.
    localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [CODE_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [CODE_W-1:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [CODE_W-1:0] SC_CAPS_MAKE    = 8'h3A;

    // Letter range for the caps lock rule.
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 7'h7A;

    typedef logic [CHAR_W-1:0] char_t;

    localparam char_t LOWER_TAB [TAB_DEPTH] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam char_t UPPER_TAB [TAB_DEPTH] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // Decoder to ring: a character decoded by the current item.
    typedef struct packed {
        logic  valid;
        char_t ch;
    } dec_out_t;

    // Ring to output stage: outcome of the current item.
    typedef struct packed {
        logic pop_ok;
        logic dropped;
        logic has_input;
    } ring_stat_t;

endpackage

/* hw/rtl/scancode_to_ascii_with_fifo_top.sv */
// ----------------------------------------------------------------------------
// scancode_to_ascii_with_fifo_top
// Set-1 keyboard scan code decoder with a buffered character ring.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle unless m_tready stalls it,
// and presents its result in the cycle after acceptance through a single
// output register and the ring's read register. An item is a scan code
// (s_tuser = 0) or a request to read one buffered character (s_tuser = 1).
// Every item gives exactly one result. Shift make and break codes and the
// caps lock code only change the keyboard flags. The ring holds up to 255
// characters; a character decoded while it is full is still echoed and is
// flagged as dropped. A read of an empty ring returns read_valid = 0. No
// clearing pass runs after reset: the block takes items at once.
// ----------------------------------------------------------------------------
module scancode_to_ascii_with_fifo_top
    import sc2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scan_code
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [0] echo_valid, [7:1] echo_char,
                                   // [8] read_valid, [15:9] read_char,
                                   // [16] dropped, [17] has_input, [23:18] 0
);

    logic       accept;
    logic       scan_en;
    logic       read_en;
    opcode_t    opcode;
    dec_out_t   dec_out;
    ring_stat_t stat;
    char_t      rd_data;

    logic  out_valid_reg;
    logic  echo_valid_reg;
    char_t echo_char_reg;
    logic  read_valid_reg;
    logic  dropped_reg;
    logic  has_input_reg;
    char_t read_char;

    // Input handshake: a new item enters whenever the output register frees.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign opcode   = opcode_t'(s_tuser);
    assign scan_en  = accept && (opcode == OP_SCAN);
    assign read_en  = accept && (opcode == OP_READ);

    sc2a_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .scan_en   (scan_en),
        .scan_code (s_tdata),
        .dec_out   (dec_out)
    );

    sc2a_ring u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_req  (scan_en && dec_out.valid),
        .wr_char   (dec_out.ch),
        .pop_req   (read_en),
        .stat      (stat),
        .rd_data   (rd_data)
    );

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    // Output payload, loaded with each accepted item.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            echo_valid_reg <= scan_en && dec_out.valid;
            echo_char_reg  <= scan_en ? dec_out.ch : '0;
            read_valid_reg <= stat.pop_ok;
            dropped_reg    <= scan_en && stat.dropped;
            has_input_reg  <= stat.has_input;
        end
    end

    // The popped character comes straight from the ring's read register.
    assign read_char = read_valid_reg ? rd_data : '0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, has_input_reg, dropped_reg, read_char, read_valid_reg,
                       echo_char_reg, echo_valid_reg};

endmodule

/* hw/rtl/sc2a_decode.sv */
// ----------------------------------------------------------------------------
// sc2a_decode
// Keeps the shift and caps lock flags and turns a set-1 make code into a
// character through the key tables.
// ----------------------------------------------------------------------------
module sc2a_decode
    import sc2a_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              scan_en,   // a scan code item is accepted
    input  logic [CODE_W-1:0] scan_code,
    output dec_out_t          dec_out
);

    logic shift_reg, shift_next;
    logic caps_reg, caps_next;

    logic                 in_table;
    logic [TAB_IDX_W-1:0] tab_idx;
    char_t                lo_ch;
    char_t                up_ch;
    char_t                sel_ch;
    logic                 is_letter;
    logic                 pick_shifted;
    logic                 is_special;

    // Modifier keys update the flags; every other code leaves them.
    always_comb
    begin
        shift_next = shift_reg;
        caps_next  = caps_reg;
        is_special = 1'b1;
        case (scan_code)
            SC_LSHIFT_MAKE, SC_RSHIFT_MAKE:   shift_next = 1'b1;
            SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: shift_next = 1'b0;
            SC_CAPS_MAKE:                     caps_next  = ~caps_reg;
            default:                          is_special = 1'b0;
        endcase
    end

    // Table lookup; the flags seen are those left by the previous item.
    always_comb
    begin
        in_table     = (scan_code[CODE_W-1:TAB_IDX_W] == '0);
        tab_idx      = scan_code[TAB_IDX_W-1:0];
        lo_ch        = LOWER_TAB[tab_idx];
        up_ch        = UPPER_TAB[tab_idx];
        is_letter    = (lo_ch >= CH_LOWER_A) && (lo_ch <= CH_LOWER_Z);
        pick_shifted = is_letter ? (shift_reg ^ caps_reg) : shift_reg;
        sel_ch       = pick_shifted ? up_ch : lo_ch;
        dec_out.valid = in_table && !is_special && (sel_ch != '0);
        dec_out.ch    = dec_out.valid ? sel_ch : '0;
    end

    // Flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
            caps_reg  <= 1'b0;
        end
        else if (scan_en)
        begin
            shift_reg <= shift_next;
            caps_reg  <= caps_next;
        end
    end

endmodule

/* hw/rtl/sc2a_ring.sv */
// ----------------------------------------------------------------------------
// sc2a_ring
// Character ring in a synchronous memory with one write and one read port.
// Pointers move in the cycle an item is accepted; popped data is registered.
// ----------------------------------------------------------------------------
`include "scancode_to_ascii_with_fifo_top_defines.svh"

module sc2a_ring
    import sc2a_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_req,   // a decoded character wants a slot
    input  char_t      wr_char,
    input  logic       pop_req,    // a read item is accepted
    output ring_stat_t stat,
    output char_t      rd_data     // valid the cycle after a successful pop
);

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_inc;
    logic             empty;
    logic             full;
    logic             do_push;
    logic             do_pop;

    char_t ring_mem [RING_DEPTH];
    char_t rd_data_reg;

    // Pointer arithmetic with wrap at the ring depth.
    always_comb
    begin
        wr_ptr_inc = (wr_ptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_inc = (rd_ptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        empty      = (wr_ptr_reg == rd_ptr_reg);
        full       = (wr_ptr_inc == rd_ptr_reg);
        do_push    = push_req && !full;
        do_pop     = pop_req && !empty;
        wr_ptr_next = do_push ? wr_ptr_inc : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_inc : rd_ptr_reg;
        stat.pop_ok    = do_pop;
        stat.dropped   = push_req && full;
        stat.has_input = (wr_ptr_next != rd_ptr_next);
    end

    // Pointer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Memory ports. A pop never addresses the slot written in the same cycle,
    // since a non-empty ring has the read pointer behind the write pointer.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ring_mem[wr_ptr_reg] <= wr_char;
        end
        if (do_pop)
        begin
            rd_data_reg <= ring_mem[rd_ptr_reg];
        end
    end

    assign rd_data = rd_data_reg;

    // Checks on the ring bookkeeping.
    `SC2A_ASSERT_IMP(a_pop_not_empty, do_pop, wr_ptr_reg != rd_ptr_reg)
    `SC2A_ASSERT_IMP(a_push_not_full, do_push, wr_ptr_inc != rd_ptr_reg)
    `SC2A_ASSERT_NEXT(a_push_fills, do_push && !pop_req, wr_ptr_reg != rd_ptr_reg)
    `SC2A_ASSERT(a_ptr_range, (wr_ptr_reg <= PTR_W'(RING_DEPTH - 1)) && (rd_ptr_reg <= PTR_W'(RING_DEPTH - 1)))

endmodule
